>>> rtl/core/distance_3d_newton_sqrt_macros.svh
// Assertion macros used by the distance block top level.
`ifndef DISTANCE_3D_NEWTON_SQRT_MACROS_SVH
`define DISTANCE_3D_NEWTON_SQRT_MACROS_SVH

// Checks that a condition implies a consequence on the same clock edge.
`define D3NS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence on the following clock edge.
`define D3NS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/d3ns_pkg.sv
// Shared types and constants for the 3D distance block.
package d3ns_pkg;

    localparam int IN_W   = 24;
    localparam int DIST_W = 25;
    localparam int EXP_W  = 8;
    localparam int LZ_W   = 6;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic                    valid;
        logic [LZ_W-1:0]         lz;
    } norm_ctl_t;

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic signed [EXP_W-1:0] half_exp;
    } root_ctl_t;

endpackage

>>> rtl/core/d3ns_front.sv
// Difference, square and sum stages that form the squared distance.
module d3ns_front
    import d3ns_pkg::*;
#(
    parameter int CW = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     ax,
    input  logic [IN_W-1:0]     ay,
    input  logic [IN_W-1:0]     az,
    input  logic [IN_W-1:0]     bx,
    input  logic [IN_W-1:0]     by,
    input  logic [IN_W-1:0]     bz,
    output logic                sum_valid,
    output logic [2*CW+1:0]     sum
);

    localparam int SW = 2*CW + 2;

    logic signed [CW:0] dx, dy, dz;
    logic [CW-1:0]      abs_x_next, abs_y_next, abs_z_next;
    logic [CW-1:0]      abs_x_reg, abs_y_reg, abs_z_reg;
    logic [2*CW-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SW-1:0]      sum_next, sum_reg;
    logic               v1_reg, v2_reg, v3_reg;

    assign dx = $signed({ax[CW-1], ax[CW-1:0]}) - $signed({bx[CW-1], bx[CW-1:0]});
    assign dy = $signed({ay[CW-1], ay[CW-1:0]}) - $signed({by[CW-1], by[CW-1:0]});
    assign dz = $signed({az[CW-1], az[CW-1:0]}) - $signed({bz[CW-1], bz[CW-1:0]});

    always_comb
    begin
        abs_x_next = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        abs_y_next = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        abs_z_next = dz[CW] ? CW'(-dz) : dz[CW-1:0];
        sum_next   = SW'(sq_x_reg) + SW'(sq_y_reg) + SW'(sq_z_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_x_reg <= abs_x_next;
            abs_y_reg <= abs_y_next;
            abs_z_reg <= abs_z_next;
            sq_x_reg  <= abs_x_reg * abs_x_reg;
            sq_y_reg  <= abs_y_reg * abs_y_reg;
            sq_z_reg  <= abs_z_reg * abs_z_reg;
            sum_reg   <= sum_next;
        end
    end

    assign sum_valid = v3_reg;
    assign sum       = sum_reg;

endmodule

>>> rtl/core/d3ns_norm_cell.sv
// One normalization cell: shifts out a fixed run of leading zeros.
module d3ns_norm_cell
    import d3ns_pkg::*;
#(
    parameter int SW    = 50,
    parameter int SHIFT = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  norm_ctl_t     in_ctl,
    input  logic [SW-1:0] in_word,
    output norm_ctl_t     out_ctl,
    output logic [SW-1:0] out_word
);

    norm_ctl_t       ctl_next;
    logic            valid_reg;
    logic [LZ_W-1:0] lz_reg;
    logic [SW-1:0]   word_next, word_reg;

    always_comb
    begin
        ctl_next  = in_ctl;
        word_next = in_word;
        if (in_word[SW-1 -: SHIFT] == '0)
        begin
            word_next  = in_word << SHIFT;
            ctl_next.lz = in_ctl.lz + LZ_W'(SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lz_reg   <= ctl_next.lz;
            word_reg <= word_next;
        end
    end

    assign out_ctl  = {valid_reg, lz_reg};
    assign out_word = word_reg;

endmodule

>>> rtl/core/d3ns_div_cell.sv
// One restoring division cell; the cell for quotient bit zero also averages the iterate.
module d3ns_div_cell
    import d3ns_pkg::*;
#(
    parameter int F   = 32,
    parameter int BIT = 0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  root_ctl_t    in_ctl,
    input  logic [F:0]   in_m,
    input  logic [F+1:0] in_a,
    input  logic [F+1:0] in_r,
    input  logic [F+1:0] in_q,
    output root_ctl_t    out_ctl,
    output logic [F:0]   out_m,
    output logic [F+1:0] out_a,
    output logic [F+1:0] out_r,
    output logic [F+1:0] out_q
);

    logic [F+1:0] r_cur;
    logic         nbit;
    logic [F+2:0] t;
    logic         ge;
    logic [F+1:0] r_next, q_next, a_next;
    logic [F+2:0] avg;
    logic                    valid_reg;
    logic                    zero_reg;
    logic signed [EXP_W-1:0] half_exp_reg;
    logic [F:0]   m_reg;
    logic [F+1:0] a_reg, r_reg, q_reg;

    generate
        if (BIT == F + 1)
        begin : g_first
            assign r_cur = (F+2)'(in_m >> 2);
        end
        else
        begin : g_rest
            assign r_cur = in_r;
        end
        if (BIT >= F)
        begin : g_mbit
            assign nbit = in_m[BIT-F];
        end
        else
        begin : g_zbit
            assign nbit = 1'b0;
        end
    endgenerate

    always_comb
    begin
        t      = {r_cur, nbit};
        ge     = (t >= {1'b0, in_a});
        r_next = ge ? (F+2)'(t - {1'b0, in_a}) : t[F+1:0];
        q_next = in_q;
        q_next[BIT] = ge;
        avg    = (F+3)'(in_a) + (F+3)'(q_next);
        a_next = (BIT == 0) ? avg[F+2:1] : in_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg     <= in_ctl.zero;
            half_exp_reg <= in_ctl.half_exp;
            m_reg        <= in_m;
            a_reg        <= a_next;
            r_reg        <= r_next;
            q_reg        <= (BIT == 0) ? '0 : q_next;
        end
    end

    assign out_ctl = {valid_reg, zero_reg, half_exp_reg};
    assign out_m   = m_reg;
    assign out_a   = a_reg;
    assign out_r   = r_reg;
    assign out_q   = q_reg;

endmodule

>>> rtl/core/distance_3d_newton_sqrt.sv
// Top level of the pipelined 3D distance unit with a Newton square root.
// The unit accepts one pair of points per cycle unless the output stalls, and returns one
// distance per request, in order. The difference, square and sum registers form the squared
// sum, a chain of shift cells normalizes it, and every Newton step runs through a row of
// MANTISSA_FRACTION+2 division cells that each settle one quotient bit. A stall on the output
// freezes the whole chain.
module distance_3d_newton_sqrt
    import d3ns_pkg::*;
#(
    parameter int NEWTON_STEPS      = 5,
    parameter int COORD_WIDTH       = 24,
    parameter int MANTISSA_FRACTION = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [IN_W-1:0]   first_x,
    input  logic [IN_W-1:0]   first_y,
    input  logic [IN_W-1:0]   first_z,
    input  logic [IN_W-1:0]   second_x,
    input  logic [IN_W-1:0]   second_y,
    input  logic [IN_W-1:0]   second_z,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIST_W-1:0] distance
);

    `include "distance_3d_newton_sqrt_macros.svh"

    localparam int F      = MANTISSA_FRACTION;
    localparam int SW     = 2*COORD_WIDTH + 2;
    localparam int NSTG   = $clog2(SW);
    localparam int DCELLS = NEWTON_STEPS * (F + 2);
    localparam int WIDE   = F + 2 + 32;

    logic              adv;
    logic              sum_valid;
    logic [SW-1:0]     sum;

    norm_ctl_t         nctl [NSTG+1];
    logic [SW-1:0]     nword [NSTG+1];

    logic [LZ_W-1:0]   p;
    logic [F-1:0]      mant;
    logic [F:0]        m_prep;
    root_ctl_t         prep_ctl_next;
    logic                    prep_valid_reg;
    logic                    prep_zero_reg;
    logic signed [EXP_W-1:0] prep_half_exp_reg;
    logic [F:0]        prep_m_reg;

    root_ctl_t         dctl [DCELLS+1];
    logic [F:0]        dm   [DCELLS+1];
    logic [F+1:0]      da   [DCELLS+1];
    logic [F+1:0]      dr   [DCELLS+1];
    logic [F+1:0]      dq   [DCELLS+1];

    logic signed [EXP_W-1:0] sh;
    logic [EXP_W-1:0]        rsh;
    logic [WIDE-1:0]         wide;
    logic [F+1:0]            rsv;
    logic [DIST_W-1:0]       dist_next, dist_reg;
    logic                    out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    d3ns_front #(.CW(COORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .ax        (first_x),
        .ay        (first_y),
        .az        (first_z),
        .bx        (second_x),
        .by        (second_y),
        .bz        (second_z),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    assign nctl[0].valid = sum_valid;
    assign nctl[0].lz    = '0;
    assign nword[0]      = sum;

    generate
        for (genvar k = 0; k < NSTG; k++)
        begin : g_norm
            d3ns_norm_cell #(.SW(SW), .SHIFT(1 << (NSTG - 1 - k))) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .in_ctl   (nctl[k]),
                .in_word  (nword[k]),
                .out_ctl  (nctl[k+1]),
                .out_word (nword[k+1])
            );
        end
        if (SW >= F)
        begin : g_mant_cut
            assign mant = nword[NSTG][SW-1 -: F];
        end
        else
        begin : g_mant_pad
            assign mant = {nword[NSTG], {(F-SW){1'b0}}};
        end
    endgenerate

    always_comb
    begin
        p = LZ_W'(SW - 1) - nctl[NSTG].lz;
        m_prep = p[0] ? {1'b0, mant} : {mant, 1'b0};
        prep_ctl_next.valid    = nctl[NSTG].valid;
        prep_ctl_next.zero     = (nword[NSTG] == '0);
        prep_ctl_next.half_exp = $signed(EXP_W'(p) - EXP_W'(15)) >>> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prep_valid_reg <= prep_ctl_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_zero_reg     <= prep_ctl_next.zero;
            prep_half_exp_reg <= prep_ctl_next.half_exp;
            prep_m_reg        <= m_prep;
        end
    end

    assign dctl[0] = {prep_valid_reg, prep_zero_reg, prep_half_exp_reg};
    assign dm[0]   = prep_m_reg;
    assign da[0]   = (F+2)'(1) << F;
    assign dr[0]   = '0;
    assign dq[0]   = '0;

    generate
        for (genvar s = 0; s < NEWTON_STEPS; s++)
        begin : g_step
            for (genvar b = 0; b < F + 2; b++)
            begin : g_bit
                localparam int IDX = s*(F+2) + b;
                d3ns_div_cell #(.F(F), .BIT(F + 1 - b)) u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .en      (adv),
                    .in_ctl  (dctl[IDX]),
                    .in_m    (dm[IDX]),
                    .in_a    (da[IDX]),
                    .in_r    (dr[IDX]),
                    .in_q    (dq[IDX]),
                    .out_ctl (dctl[IDX+1]),
                    .out_m   (dm[IDX+1]),
                    .out_a   (da[IDX+1]),
                    .out_r   (dr[IDX+1]),
                    .out_q   (dq[IDX+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        sh   = dctl[DCELLS].half_exp + EXP_W'(8) - EXP_W'(F);
        rsh  = EXP_W'(-sh);
        wide = WIDE'(da[DCELLS]) << sh[4:0];
        rsv  = da[DCELLS] >> rsh;
        if (dctl[DCELLS].zero)
        begin
            dist_next = '0;
        end
        else if (!sh[EXP_W-1])
        begin
            dist_next = (wide > WIDE'(DIST_MAX)) ? DIST_MAX : wide[DIST_W-1:0];
        end
        else
        begin
            dist_next = ((F+2+DIST_W)'(rsv) > (F+2+DIST_W)'(DIST_MAX)) ?
                        DIST_MAX : DIST_W'(rsv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dctl[DCELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;

    `D3NS_ASSERT_NEXT(a_stall_holds, !adv, $stable(dctl[DCELLS].valid), "chain moved during a stall")
    `D3NS_ASSERT_NOW(a_norm_msb, nctl[NSTG].valid && (nword[NSTG] != '0), nword[NSTG][SW-1], "normalized sum lost its leading one")
    `D3NS_ASSERT_NOW(a_iter_floor, dctl[DCELLS].valid && !dctl[DCELLS].zero, da[DCELLS][F+1:F-1] != '0, "Newton iterate fell below one half")

endmodule

>>> sim/tb_distance_3d_newton_sqrt.sv
// Testbench for the 3D distance unit: random and directed point pairs checked against a predictor.
`timescale 1ns / 1ps

module tb_distance_3d_newton_sqrt;
    import d3ns_pkg::*;

    localparam int STEPS     = 5;
    localparam int MANT_FRAC = 32;
    localparam int LATENCY   = 181;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [IN_W-1:0]   first_x;
    logic [IN_W-1:0]   first_y;
    logic [IN_W-1:0]   first_z;
    logic [IN_W-1:0]   second_x;
    logic [IN_W-1:0]   second_y;
    logic [IN_W-1:0]   second_z;
    logic              out_valid;
    logic              out_ready;
    logic [DIST_W-1:0] distance;

    logic [DIST_W-1:0] expected_distances[$];
    int                error_count;
    int                hold_off_cycles;
    bit                random_idle;

    distance_3d_newton_sqrt u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .first_x   (first_x),
        .first_y   (first_y),
        .first_z   (first_z),
        .second_x  (second_x),
        .second_y  (second_y),
        .second_z  (second_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] square_diff(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0)
        begin
            d = -d;
        end
        return 64'(d) * 64'(d);
    endfunction

    function automatic logic [63:0] frac_quotient(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        if (den == 0)
        begin
            return 0;
        end
        q = num / den;
        r = num % den;
        for (int i = 0; i < MANT_FRAC; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(logic [IN_W-1:0] ax,
        logic [IN_W-1:0] ay, logic [IN_W-1:0] az, logic [IN_W-1:0] bx,
        logic [IN_W-1:0] by, logic [IN_W-1:0] bz);
        logic [63:0] sum;
        logic [63:0] mant;
        logic [63:0] root;
        logic [63:0] res;
        int          msb;
        int          expo;
        int          sh;
        sum = square_diff(ax, bx) + square_diff(ay, by) + square_diff(az, bz);
        if (sum == 0)
        begin
            return '0;
        end
        msb = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (sum[i])
            begin
                msb = i;
            end
        end
        expo = msb - 15;
        sh = MANT_FRAC - msb - 1;
        mant = (sh >= 0) ? (sum << sh) : (sum >> (-sh));
        if (msb % 2 == 0)
        begin
            mant = mant << 1;
            expo = expo - 1;
        end
        root = 64'd1 << MANT_FRAC;
        for (int i = 0; i < STEPS; i++)
        begin
            root = (root + frac_quotient(mant, root)) >> 1;
        end
        sh = expo / 2 + 8 - MANT_FRAC;
        if (sh >= 0)
        begin
            if (sh >= 40 || (root >> (63 - sh)) != 0)
            begin
                return DIST_MAX;
            end
            res = root << sh;
        end
        else if (-sh >= 64)
        begin
            res = 0;
        end
        else
        begin
            res = root >> (-sh);
        end
        if (res > 64'(DIST_MAX))
        begin
            res = 64'(DIST_MAX);
        end
        return res[DIST_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic send_request(logic [IN_W-1:0] ax, logic [IN_W-1:0] ay,
        logic [IN_W-1:0] az, logic [IN_W-1:0] bx, logic [IN_W-1:0] by,
        logic [IN_W-1:0] bz);
        int gap;
        gap = random_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_x  <= ax;
        first_y  <= ay;
        first_z  <= az;
        second_x <= bx;
        second_y <= by;
        second_z <= bz;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_distances.push_back(predict_distance(ax, ay, az, bx, by, bz));
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_distances.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [IN_W-1:0] random_coord(int bits);
        logic [IN_W-1:0] v;
        v = IN_W'($urandom);
        if (bits < IN_W)
        begin
            v = IN_W'($signed(v << (IN_W - bits)) >>> (IN_W - bits));
        end
        return v;
    endfunction

    task automatic test_extremes();
        logic [IN_W-1:0] mx;
        logic [IN_W-1:0] mn;
        mx = 24'h7FFFFF;
        mn = 24'h800000;
        send_request(0, 0, 0, 0, 0, 0);
        send_request(mx, mx, mx, mx, mx, mx);
        send_request(mn, mn, mn, mn, mn, mn);
        send_request(mx, mx, mx, mn, mn, mn);
        send_request(mn, mn, mn, mx, mx, mx);
        send_request(mx, 0, 0, mn, 0, 0);
        send_request(0, mn, 0, 0, mx, 0);
        send_request(0, 0, 1, 0, 0, 0);
        send_request(1, 1, 1, 0, 0, 0);
        send_request(0, 0, 0, 24'hFFFFFF, 0, 0);
        send_request(24'h000100, 0, 0, 0, 0, 0);
        send_request(24'h000200, 0, 0, 0, 0, 0);
        send_request(24'h000300, 24'h000400, 0, 0, 0, 0);
        send_request(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_request(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555);
        send_request(2, 0, 0, 0, 0, 0);
        send_request(0, 3, 0, 0, 0, 0);
        stop_sending();
    endtask

    task automatic test_random(int count);
        int bits;
        for (int i = 0; i < count; i++)
        begin
            bits = ($urandom_range(0, 3) == 0) ? IN_W : $urandom_range(1, IN_W);
            send_request(random_coord(bits), random_coord(bits), random_coord(bits),
                         random_coord(bits), random_coord(bits), random_coord(bits));
        end
        stop_sending();
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 400;
        random_idle = 1'b0;
        test_random(250);
        random_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (random_idle)
            begin
                out_ready <= ($urandom_range(0, 6) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_distances.size() == 0)
            begin
                report_mismatch($sformatf("unexpected distance %0d", distance));
            end
            else
            begin
                if (distance !== expected_distances[0])
                begin
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              distance, expected_distances[0]));
                end
                expected_distances.pop_front();
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        first_x = '0;
        first_y = '0;
        first_z = '0;
        second_x = '0;
        second_y = '0;
        second_z = '0;
        error_count = 0;
        hold_off_cycles = 0;
        random_idle = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        random_idle = 1'b1;
        test_random(200);
        test_back_pressure();
        test_sender_pause();
        random_idle = 1'b0;
        test_random(150);
        random_idle = 1'b1;
        test_random(300);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
